// ----- rtl/i2c_bit_level_master_macros.svh -----
// assertion helpers, clocked on i_clk and held off while i_rst_n is low
`ifndef I2C_BIT_LEVEL_MASTER_MACROS_SVH
`define I2C_BIT_LEVEL_MASTER_MACROS_SVH

// property that holds on every edge
`define I2C_BLM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define I2C_BLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/i2c_blm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package i2c_blm_pkg;

    localparam int WAIT_BITS_DEF = 16;
    localparam int CFG_W         = 16;
    localparam int Q_DEPTH       = 2;

    localparam logic [CFG_W-1:0] HALF_BIT_RESET   = 16'd5;
    localparam logic [CFG_W-1:0] ACK_SAMPLE_RESET = 16'd2;

    typedef enum logic [0:0] {
        CFG_HALF_BIT   = 1'b0,
        CFG_ACK_SAMPLE = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        OP_START     = 3'd0,
        OP_STOP      = 3'd1,
        OP_WRITE     = 3'd2,
        OP_READ      = 3'd3,
        OP_SEND_ACK  = 3'd4,
        OP_CHECK_ACK = 3'd5
    } t_op;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'd0,
        PH_START_A  = 5'd1,
        PH_START_B  = 5'd2,
        PH_STOP_A   = 5'd3,
        PH_STOP_B   = 5'd4,
        PH_WR_LOW   = 5'd5,
        PH_WR_HIGH  = 5'd6,
        PH_RD_LOW   = 5'd7,
        PH_RD_HIGH  = 5'd8,
        PH_ACK_HIGH = 5'd9,
        PH_CHK      = 5'd10
    } t_phase;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] operation;
        logic [7:0] write_byte;
        logic       ack_to_send;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_level;
    } t_out_item;

    // classified tick as it sits in the queue
    typedef struct packed {
        logic       cmd_ok;
        t_op        op;
        logic [7:0] data;
        logic       ack;
        logic       sda;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_flags;

endpackage

`default_nettype wire

// ----- rtl/i2c_blm_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module i2c_blm_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  i2c_blm_pkg::t_cmd    i_push_data,
    input  wire                  i_pop,
    output i2c_blm_pkg::t_cmd    o_head,
    output i2c_blm_pkg::t_q_flags o_flags
);

    localparam int DEPTH = i2c_blm_pkg::Q_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    i2c_blm_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_push_ok;
    logic          w_pop_ok;

    assign w_push_ok = i_push && !o_flags.full;
    assign w_pop_ok  = i_pop && !o_flags.empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (w_push_ok) begin
            n_wp = (r_wp == LAST) ? '0 : r_wp + PW'(1);
        end
        if (w_pop_ok) begin
            n_rp = (r_rp == LAST) ? '0 : r_rp + PW'(1);
        end
        if (w_push_ok && !w_pop_ok) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_pop_ok && !w_push_ok) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wp] <= i_push_data;
        end
    end

    assign o_head        = r_mem[r_rp];
    assign o_flags.empty = (r_cnt == '0);
    assign o_flags.full  = (r_cnt == CW'(DEPTH));

endmodule

`default_nettype wire

// ----- rtl/i2c_blm_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

module i2c_blm_engine #(
    parameter int WAIT_BITS = i2c_blm_pkg::WAIT_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire [i2c_blm_pkg::CFG_W-1:0]       i_half_bit_ticks,
    input  wire [i2c_blm_pkg::CFG_W-1:0]       i_ack_sample_ticks,
    input  i2c_blm_pkg::t_cmd                  i_head,
    input  wire                                i_q_empty,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output i2c_blm_pkg::t_out_item             o_out
);

    localparam int CFG_W = i2c_blm_pkg::CFG_W;
    localparam int EXT_W = (WAIT_BITS > CFG_W) ? WAIT_BITS : CFG_W;

    i2c_blm_pkg::t_phase    r_phase, n_phase;
    logic [WAIT_BITS-1:0]   r_wait, n_wait;
    logic [7:0]             r_shift, n_shift;
    logic [2:0]             r_bit, n_bit;
    logic                   r_scl, n_scl;
    logic                   r_sda, n_sda;
    logic                   r_en, n_en;
    logic                   r_ack, n_ack;
    logic [7:0]             r_last, n_last;
    logic                   n_done;
    logic                   r_out_valid;
    i2c_blm_pkg::t_out_item r_out, n_out;

    logic [EXT_W-1:0]       w_half_ext, w_ack_ext;
    logic [WAIT_BITS-1:0]   w_half_load, w_ack_load;
    logic [7:0]             w_rd_shift;

    assign o_pop = !i_q_empty && !(r_out_valid && i_out_stall);

    // masked wait lengths, zero counts as one tick
    always_comb begin
        w_half_ext  = EXT_W'(i_half_bit_ticks);
        w_ack_ext   = EXT_W'(i_ack_sample_ticks);
        w_half_load = (w_half_ext[WAIT_BITS-1:0] == '0) ? WAIT_BITS'(1)
                                                       : w_half_ext[WAIT_BITS-1:0];
        w_ack_load  = (w_ack_ext[WAIT_BITS-1:0] == '0) ? WAIT_BITS'(1)
                                                      : w_ack_ext[WAIT_BITS-1:0];
        w_rd_shift  = {r_shift[6:0], i_head.sda};
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_wait  = r_wait;
        n_shift = r_shift;
        n_bit   = r_bit;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_en    = r_en;
        n_ack   = r_ack;
        n_last  = r_last;
        n_done  = 1'b0;
        if (o_pop) begin
            if (r_phase == i2c_blm_pkg::PH_IDLE) begin
                if (i_head.cmd_ok) begin
                    unique case (i_head.op)
                        i2c_blm_pkg::OP_START: begin
                            n_scl   = 1'b1;
                            n_en    = 1'b1;
                            n_sda   = 1'b1;
                            n_wait  = w_half_load;
                            n_phase = i2c_blm_pkg::PH_START_A;
                        end
                        i2c_blm_pkg::OP_STOP: begin
                            n_scl   = 1'b1;
                            n_en    = 1'b1;
                            n_sda   = 1'b0;
                            n_wait  = w_half_load;
                            n_phase = i2c_blm_pkg::PH_STOP_A;
                        end
                        i2c_blm_pkg::OP_WRITE: begin
                            n_shift = i_head.data;
                            n_bit   = 3'd7;
                            n_scl   = 1'b0;
                            n_en    = 1'b1;
                            n_sda   = i_head.data[7];
                            n_wait  = w_half_load;
                            n_phase = i2c_blm_pkg::PH_WR_LOW;
                        end
                        i2c_blm_pkg::OP_READ: begin
                            n_shift = '0;
                            n_bit   = 3'd7;
                            n_en    = 1'b0;
                            n_sda   = 1'b1;
                            n_scl   = 1'b0;
                            n_wait  = w_half_load;
                            n_phase = i2c_blm_pkg::PH_RD_LOW;
                        end
                        i2c_blm_pkg::OP_SEND_ACK: begin
                            n_en    = 1'b1;
                            n_sda   = !i_head.ack;
                            n_scl   = 1'b1;
                            n_wait  = w_half_load;
                            n_phase = i2c_blm_pkg::PH_ACK_HIGH;
                        end
                        i2c_blm_pkg::OP_CHECK_ACK: begin
                            n_en    = 1'b0;
                            n_sda   = 1'b1;
                            n_scl   = 1'b1;
                            n_wait  = w_ack_load;
                            n_phase = i2c_blm_pkg::PH_CHK;
                        end
                        default: ;
                    endcase
                end
            end else if (r_wait > WAIT_BITS'(1)) begin
                n_wait = r_wait - WAIT_BITS'(1);
            end else begin
                n_wait = '0;
                unique case (r_phase)
                    i2c_blm_pkg::PH_START_A: begin
                        n_en    = 1'b1;
                        n_sda   = 1'b0;
                        n_wait  = w_half_load;
                        n_phase = i2c_blm_pkg::PH_START_B;
                    end
                    i2c_blm_pkg::PH_STOP_A: begin
                        n_en    = 1'b1;
                        n_sda   = 1'b1;
                        n_wait  = w_half_load;
                        n_phase = i2c_blm_pkg::PH_STOP_B;
                    end
                    i2c_blm_pkg::PH_WR_LOW, i2c_blm_pkg::PH_RD_LOW: begin
                        n_scl   = 1'b1;
                        n_wait  = w_half_load;
                        n_phase = (r_phase == i2c_blm_pkg::PH_WR_LOW) ?
                                  i2c_blm_pkg::PH_WR_HIGH : i2c_blm_pkg::PH_RD_HIGH;
                    end
                    i2c_blm_pkg::PH_WR_HIGH: begin
                        n_scl = 1'b0;
                        if (r_bit != 3'd0) begin
                            n_bit   = r_bit - 3'd1;
                            n_en    = 1'b1;
                            n_sda   = r_shift[r_bit - 3'd1];
                            n_wait  = w_half_load;
                            n_phase = i2c_blm_pkg::PH_WR_LOW;
                        end else begin
                            n_done  = 1'b1;
                            n_phase = i2c_blm_pkg::PH_IDLE;
                        end
                    end
                    i2c_blm_pkg::PH_RD_HIGH: begin
                        n_shift = w_rd_shift;
                        if (r_bit != 3'd0) begin
                            n_bit   = r_bit - 3'd1;
                            n_scl   = 1'b0;
                            n_wait  = w_half_load;
                            n_phase = i2c_blm_pkg::PH_RD_LOW;
                        end else begin
                            n_last  = w_rd_shift;
                            n_done  = 1'b1;
                            n_phase = i2c_blm_pkg::PH_IDLE;
                        end
                    end
                    i2c_blm_pkg::PH_ACK_HIGH: begin
                        n_scl   = 1'b0;
                        n_done  = 1'b1;
                        n_phase = i2c_blm_pkg::PH_IDLE;
                    end
                    i2c_blm_pkg::PH_CHK: begin
                        n_ack = i_head.sda;
                        if (i_head.sda) begin
                            // no ack: fall into a stop
                            n_scl   = 1'b1;
                            n_en    = 1'b1;
                            n_sda   = 1'b0;
                            n_wait  = w_half_load;
                            n_phase = i2c_blm_pkg::PH_STOP_A;
                        end else begin
                            n_done  = 1'b1;
                            n_phase = i2c_blm_pkg::PH_IDLE;
                        end
                    end
                    default: begin
                        n_done  = 1'b1;
                        n_phase = i2c_blm_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // result beat from the levels after this tick
    always_comb begin
        n_out.scl       = n_scl;
        n_out.sda_level = n_en ? n_sda : 1'b1;
        n_out.sda_drive = n_en;
        n_out.busy_res  = (n_phase != i2c_blm_pkg::PH_IDLE);
        n_out.done_res  = n_done;
        n_out.read_byte = n_last;
        n_out.ack_level = n_ack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= i2c_blm_pkg::PH_IDLE;
            r_wait      <= '0;
            r_shift     <= '0;
            r_bit       <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_en        <= 1'b1;
            r_ack       <= 1'b0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_wait  <= n_wait;
            r_shift <= n_shift;
            r_bit   <= n_bit;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_en    <= n_en;
            r_ack   <= n_ack;
            r_last  <= n_last;
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ----- rtl/i2c_bit_level_master.sv -----
// I2C master bit engine. Every input beat is one timing tick carrying an
// optional command (start, stop, write byte, read byte, send ack/nack,
// check ack) and the sampled SDA level; every tick gives one result beat
// with SCL, SDA level and drive enable, busy, a done pulse, the last read
// byte and the last ack sample. Commands are only taken on a tick that
// begins idle; a nack seen at ack check issues a stop by itself.
// Channels use valid/stall: a beat moves when valid is high and stall low.
// Path: a tick is written into the queue, the sequencer steps it from the
// queue head and loads the output register, which offers the result beat.
// Throughput: one tick per cycle while the output is not stalled; the
// two-entry tick queue lets input and output stall apart.
// Stall on the output holds the result register; the queue fills and then
// raises o_in_stall, so no tick is lost or repeated.
// Config writes (index 0 half-bit ticks, 1 ack sample ticks) are registered
// and are meant to happen while idle.
// Reset (synchronous, active low) empties the queue, returns the sequencer
// to idle with SCL high and SDA driven high, and restores the registers
// to 5 and 2 ticks.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_bit_level_master_macros.svh"

module i2c_bit_level_master #(
    parameter int WAIT_BITS = i2c_blm_pkg::WAIT_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  i2c_blm_pkg::t_in_item        i_in,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output i2c_blm_pkg::t_out_item       o_out,
    input  wire                          i_cfg_we,
    input  i2c_blm_pkg::t_cfg_idx        i_cfg_idx,
    input  wire [i2c_blm_pkg::CFG_W-1:0] i_cfg_data
);

    logic [i2c_blm_pkg::CFG_W-1:0] r_half_bit_ticks;
    logic [i2c_blm_pkg::CFG_W-1:0] r_ack_sample_ticks;
    i2c_blm_pkg::t_cmd             w_cmd;
    i2c_blm_pkg::t_cmd             w_head;
    i2c_blm_pkg::t_q_flags         w_flags;
    logic                          w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_bit_ticks   <= i2c_blm_pkg::HALF_BIT_RESET;
            r_ack_sample_ticks <= i2c_blm_pkg::ACK_SAMPLE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                i2c_blm_pkg::CFG_HALF_BIT:   r_half_bit_ticks   <= i_cfg_data;
                i2c_blm_pkg::CFG_ACK_SAMPLE: r_ack_sample_ticks <= i_cfg_data;
            endcase
        end
    end

    // front: classify the tick, unknown operations become plain ticks
    always_comb begin
        w_cmd.data = i_in.write_byte;
        w_cmd.ack  = i_in.ack_to_send;
        w_cmd.sda  = i_in.sda_in;
        w_cmd.cmd_ok = i_in.cmd_valid;
        unique case (i_in.operation)
            i2c_blm_pkg::OP_START:     w_cmd.op = i2c_blm_pkg::OP_START;
            i2c_blm_pkg::OP_STOP:      w_cmd.op = i2c_blm_pkg::OP_STOP;
            i2c_blm_pkg::OP_WRITE:     w_cmd.op = i2c_blm_pkg::OP_WRITE;
            i2c_blm_pkg::OP_READ:      w_cmd.op = i2c_blm_pkg::OP_READ;
            i2c_blm_pkg::OP_SEND_ACK:  w_cmd.op = i2c_blm_pkg::OP_SEND_ACK;
            i2c_blm_pkg::OP_CHECK_ACK: w_cmd.op = i2c_blm_pkg::OP_CHECK_ACK;
            default: begin
                w_cmd.op     = i2c_blm_pkg::OP_START;
                w_cmd.cmd_ok = 1'b0;
            end
        endcase
    end

    i2c_blm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_in_valid),
        .i_push_data (w_cmd),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_flags     (w_flags)
    );

    assign o_in_stall = w_flags.full;

    i2c_blm_engine #(
        .WAIT_BITS (WAIT_BITS)
    ) u_engine (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_half_bit_ticks   (r_half_bit_ticks),
        .i_ack_sample_ticks (r_ack_sample_ticks),
        .i_head             (w_head),
        .i_q_empty          (w_flags.empty),
        .o_pop              (w_pop),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out              (o_out)
    );

    `I2C_BLM_ASSERT(a_done_not_busy,
        !(o_out_valid && o_out.done_res && o_out.busy_res),
        "done with busy")
    `I2C_BLM_ASSERT(a_released_high,
        !(o_out_valid && !o_out.sda_drive && !o_out.sda_level),
        "released sda low")
    `I2C_BLM_ASSERT_NEXT(a_queue_drains,
        !w_flags.empty && !(o_out_valid && i_out_stall), o_out_valid,
        "queued tick not delivered")

endmodule

`default_nettype wire
